[rtl/core/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared constants for the delta-list timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int unsigned SLOTS_DEF      = 16;
   localparam int unsigned DELAY_BITS_DEF = 16;
   localparam int unsigned SLOT_W         = 4;
   localparam int unsigned DELAY_W        = 16;
   localparam int unsigned MAX_WAKE       = 16;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

endpackage

[rtl/core/dtq_if.sv]
// ----------------------------------------------------------------------------
// dtq_if
// Request and response channels of the timer queue.
// ----------------------------------------------------------------------------
interface dtq_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [dtq_pkg::SLOT_W-1:0]  slot;
   logic [dtq_pkg::DELAY_W-1:0] delay;

   modport source (output valid, output cmd, output slot, output delay, input ready);
   modport sink   (input valid, input cmd, input slot, input delay, output ready);
endinterface

interface dtq_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [dtq_pkg::SLOT_W-1:0] woken_slot;
   logic                       last;

   modport source (output valid, output woken_slot, output last, input ready);
   modport sink   (input valid, input woken_slot, input last, output ready);
endinterface

[rtl/core/delta_timer_queue.sv]
// ----------------------------------------------------------------------------
// delta_timer_queue
// Sorted delta-list timer queue, one entry per slot, list kept in memory.
// ----------------------------------------------------------------------------
//  channel  dir  fields                 carries
//  req_if   in   cmd, slot, delay       insert (cmd 0) or tick (cmd 1)
//  rsp_if   out  woken_slot, last       one per expired slot, last marks end
//
//  Insert: walks the list, one memory read per cycle, then writes the new
//  entry and the link to it; no new request is taken until it is done.
//  Tick: pops expired slots, then counts down the head; no-op if empty.
//  Reset empties the queue at once; the memories need no clearing pass.
//  A result waits in an output register; a tick stalls only when it must
//  hand on a further result while that register is still full.
// ----------------------------------------------------------------------------
module delta_timer_queue #(
   parameter int unsigned SLOTS      = dtq_pkg::SLOTS_DEF,
   parameter int unsigned DELAY_BITS = dtq_pkg::DELAY_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   dtq_req_if.sink   req_if,
   dtq_rsp_if.source rsp_if
);

   localparam int unsigned IDX_BITS = $clog2(SLOTS);
   localparam int unsigned PTR_BITS = $clog2(SLOTS + 1);

   logic [IDX_BITS-1:0]   rd_idx;
   logic [DELAY_BITS-1:0] delta_rdata;
   logic [PTR_BITS-1:0]   link_rdata;
   logic                  delta_we;
   logic [IDX_BITS-1:0]   delta_widx;
   logic [DELAY_BITS-1:0] delta_wdata;
   logic                  link_we;
   logic [IDX_BITS-1:0]   link_widx;
   logic [PTR_BITS-1:0]   link_wdata;

   dtq_store #(
      .SLOTS      (SLOTS),
      .DELAY_BITS (DELAY_BITS)
   ) u_store (
      .clock       (clock),
      .rd_idx      (rd_idx),
      .delta_we    (delta_we),
      .delta_widx  (delta_widx),
      .delta_wdata (delta_wdata),
      .link_we     (link_we),
      .link_widx   (link_widx),
      .link_wdata  (link_wdata),
      .delta_rdata (delta_rdata),
      .link_rdata  (link_rdata)
   );

   dtq_seq #(
      .SLOTS      (SLOTS),
      .DELAY_BITS (DELAY_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .rd_idx      (rd_idx),
      .delta_rdata (delta_rdata),
      .link_rdata  (link_rdata),
      .delta_we    (delta_we),
      .delta_widx  (delta_widx),
      .delta_wdata (delta_wdata),
      .link_we     (link_we),
      .link_widx   (link_widx),
      .link_wdata  (link_wdata)
   );

endmodule

[rtl/core/dtq_store.sv]
// ----------------------------------------------------------------------------
// dtq_store
// Per-slot delta and successor memories, one write and one registered read.
// ----------------------------------------------------------------------------
module dtq_store #(
   parameter  int unsigned SLOTS      = dtq_pkg::SLOTS_DEF,
   parameter  int unsigned DELAY_BITS = dtq_pkg::DELAY_BITS_DEF,
   localparam int unsigned IDX_BITS   = $clog2(SLOTS),
   localparam int unsigned PTR_BITS   = $clog2(SLOTS + 1)
) (
   input  logic                  clock,
   input  logic [IDX_BITS-1:0]   rd_idx,
   input  logic                  delta_we,
   input  logic [IDX_BITS-1:0]   delta_widx,
   input  logic [DELAY_BITS-1:0] delta_wdata,
   input  logic                  link_we,
   input  logic [IDX_BITS-1:0]   link_widx,
   input  logic [PTR_BITS-1:0]   link_wdata,
   output logic [DELAY_BITS-1:0] delta_rdata,
   output logic [PTR_BITS-1:0]   link_rdata
);

   logic [DELAY_BITS-1:0] delta_mem [SLOTS];
   logic [PTR_BITS-1:0]   link_mem  [SLOTS];
   logic [DELAY_BITS-1:0] delta_rd_ff;
   logic [PTR_BITS-1:0]   link_rd_ff;

   always_ff @(posedge clock) begin
      if (delta_we) begin
         delta_mem[delta_widx] <= delta_wdata;
      end
      delta_rd_ff <= delta_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_widx] <= link_wdata;
      end
      link_rd_ff <= link_mem[rd_idx];
   end

   assign delta_rdata = delta_rd_ff;
   assign link_rdata  = link_rd_ff;

endmodule

[rtl/core/dtq_seq.sv]
// ----------------------------------------------------------------------------
// dtq_seq
// List walker: inserts by walking the delta list, ticks by popping zero heads and counting down the next.
// ----------------------------------------------------------------------------
module dtq_seq #(
   parameter  int unsigned SLOTS      = dtq_pkg::SLOTS_DEF,
   parameter  int unsigned DELAY_BITS = dtq_pkg::DELAY_BITS_DEF,
   localparam int unsigned IDX_BITS   = $clog2(SLOTS),
   localparam int unsigned PTR_BITS   = $clog2(SLOTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   dtq_req_if.sink               req_if,
   dtq_rsp_if.source             rsp_if,
   output logic [IDX_BITS-1:0]   rd_idx,
   input  logic [DELAY_BITS-1:0] delta_rdata,
   input  logic [PTR_BITS-1:0]   link_rdata,
   output logic                  delta_we,
   output logic [IDX_BITS-1:0]   delta_widx,
   output logic [DELAY_BITS-1:0] delta_wdata,
   output logic                  link_we,
   output logic [IDX_BITS-1:0]   link_widx,
   output logic [PTR_BITS-1:0]   link_wdata
);

   localparam int unsigned CNT_BITS = $clog2(dtq_pkg::MAX_WAKE + 1);
   localparam logic [PTR_BITS-1:0] NIL = PTR_BITS'(SLOTS);
   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(dtq_pkg::MAX_WAKE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_LINK_NEW,
      ST_LINK_PREV,
      ST_TICK,
      ST_FLUSH
   } state_type;

   state_type                   state_ff, state_in;
   logic [PTR_BITS-1:0]         head_ff, head_in;
   logic [SLOTS-1:0]            mark_ff, mark_in;
   logic [PTR_BITS-1:0]         cur_ff, cur_in;
   logic [PTR_BITS-1:0]         prev_ff, prev_in;
   logic [IDX_BITS-1:0]         new_ff, new_in;
   logic [DELAY_BITS-1:0]       dly_ff, dly_in;
   logic [DELAY_BITS-1:0]       cur_dly_ff, cur_dly_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic                        pend_vld_ff, pend_vld_in;
   logic [IDX_BITS-1:0]         pend_ff, pend_in;
   logic                        out_vld_ff, out_vld_in;
   logic [dtq_pkg::SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic                        out_last_ff, out_last_in;

   logic                        out_free;
   logic [PTR_BITS-1:0]         link_n;
   logic [IDX_BITS-1:0]         cur_idx;
   logic [IDX_BITS-1:0]         req_idx;
   logic                        req_slot_ok;
   logic                        head_zero;
   logic                        pop_more;

   assign out_free    = !out_vld_ff || rsp_if.ready;
   assign link_n      = (link_rdata >= NIL) ? NIL : link_rdata;
   assign cur_idx     = cur_ff[IDX_BITS-1:0];
   assign req_idx     = IDX_BITS'(req_if.slot);
   assign req_slot_ok = (32'(req_if.slot) < SLOTS);
   assign head_zero   = (delta_rdata == '0);
   assign pop_more    = head_zero && (cnt_ff < CNT_MAX);

   // read data always belongs to the entry cur_ff points at
   assign rd_idx = cur_in[IDX_BITS-1:0];

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      mark_in     = mark_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      new_in      = new_ff;
      dly_in      = dly_ff;
      cur_dly_in  = cur_dly_ff;
      cnt_in      = cnt_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff && !rsp_if.ready;
      out_slot_in = out_slot_ff;
      out_last_in = out_last_ff;
      delta_we    = 1'b0;
      delta_widx  = cur_idx;
      delta_wdata = delta_rdata;
      link_we     = 1'b0;
      link_widx   = new_ff;
      link_wdata  = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               if (req_if.cmd == dtq_pkg::CMD_TICK) begin
                  if (head_ff != NIL) begin
                     cur_in      = head_ff;
                     cnt_in      = '0;
                     pend_vld_in = 1'b0;
                     state_in    = ST_TICK;
                  end
               end else if (req_slot_ok && !mark_ff[req_idx]) begin
                  new_in   = req_idx;
                  dly_in   = DELAY_BITS'(req_if.delay);
                  prev_in  = NIL;
                  cur_in   = head_ff;
                  state_in = (head_ff == NIL) ? ST_LINK_NEW : ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (delta_rdata < dly_ff) begin
               // step past an earlier entry
               dly_in  = dly_ff - delta_rdata;
               prev_in = cur_ff;
               cur_in  = link_n;
               if (link_n == NIL) begin
                  state_in = ST_LINK_NEW;
               end
            end else begin
               cur_dly_in = delta_rdata;
               state_in   = ST_LINK_NEW;
            end
         end

         ST_LINK_NEW: begin
            delta_we         = 1'b1;
            delta_widx       = new_ff;
            delta_wdata      = dly_ff;
            link_we          = 1'b1;
            link_widx        = new_ff;
            link_wdata       = cur_ff;
            mark_in[new_ff]  = 1'b1;
            state_in         = ST_LINK_PREV;
         end

         ST_LINK_PREV: begin
            if (cur_ff != NIL) begin
               delta_we    = 1'b1;
               delta_widx  = cur_idx;
               delta_wdata = cur_dly_ff - dly_ff;
            end
            if (prev_ff != NIL) begin
               link_we    = 1'b1;
               link_widx  = prev_ff[IDX_BITS-1:0];
               link_wdata = PTR_BITS'(new_ff);
            end else begin
               head_in = PTR_BITS'(new_ff);
            end
            state_in = ST_IDLE;
         end

         ST_TICK: begin
            // hold while the previous pop cannot be handed on
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  out_vld_in  = 1'b1;
                  out_slot_in = dtq_pkg::SLOT_W'(pend_ff);
                  out_last_in = !pop_more;
               end
               if (pop_more) begin
                  head_in          = link_n;
                  mark_in[cur_idx] = 1'b0;
                  pend_in          = cur_idx;
                  pend_vld_in      = 1'b1;
                  cnt_in           = cnt_ff + 1'b1;
                  cur_in           = link_n;
                  if (link_n == NIL) begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  if (!head_zero) begin
                     delta_we    = 1'b1;
                     delta_widx  = cur_idx;
                     delta_wdata = delta_rdata - 1'b1;
                  end
                  pend_vld_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_slot_in = dtq_pkg::SLOT_W'(pend_ff);
               out_last_in = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= NIL;
         mark_ff     <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         mark_ff     <= mark_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      new_ff      <= new_in;
      dly_ff      <= dly_in;
      cur_dly_ff  <= cur_dly_in;
      cnt_ff      <= cnt_in;
      pend_ff     <= pend_in;
      out_slot_ff <= out_slot_in;
      out_last_ff <= out_last_in;
   end

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = out_vld_ff;
   assign rsp_if.woken_slot = out_slot_ff;
   assign rsp_if.last       = out_last_ff;

endmodule

[sim/tb_delta_timer_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_timer_queue
// Feeds inserts and ticks into the timer queue and checks every woken slot,
// in order and with its last flag, against a delta-list model kept in step
// with each accepted request. Both channels idle at random until the last random phase.
// ----------------------------------------------------------------------------
module tb_delta_timer_queue;

   localparam int unsigned NSLOT       = dtq_pkg::SLOTS_DEF;
   localparam logic [4:0]  NIL_LINK    = 5'(dtq_pkg::SLOTS_DEF);
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned TAIL_CYCLES = 40;
   localparam int unsigned RAND_ITEMS  = 90;
   localparam int unsigned MAX_SHOWN   = 10;
   localparam int unsigned DIR_ROWS    = 18;

   typedef struct packed {
      logic [dtq_pkg::SLOT_W-1:0] slot;
      logic                       last;
   } wake_type;

   // fixed = 1: the row's outcome is typed in (no result, or one wake of
   // fixed_slot marked last); otherwise the model decides
   typedef struct packed {
      logic                        cmd;
      logic [dtq_pkg::SLOT_W-1:0]  slot;
      logic [dtq_pkg::DELAY_W-1:0] delay;
      logic                        fixed;
      logic                        fixed_wake;
      logic [dtq_pkg::SLOT_W-1:0]  fixed_slot;
   } dir_row_type;

   localparam dir_row_type [0:DIR_ROWS-1] DIR_TABLE = {
      {dtq_pkg::CMD_TICK,   4'd0,  16'd0,    1'b1, 1'b0, 4'd0},  // tick on empty queue
      {dtq_pkg::CMD_INSERT, 4'd3,  16'd0,    1'b1, 1'b0, 4'd0},  // zero delay
      {dtq_pkg::CMD_TICK,   4'd0,  16'd0,    1'b1, 1'b1, 4'd3},
      {dtq_pkg::CMD_INSERT, 4'd12, 16'hFFFF, 1'b1, 1'b0, 4'd0},  // longest delay
      {dtq_pkg::CMD_INSERT, 4'd5,  16'd4,    1'b1, 1'b0, 4'd0},
      {dtq_pkg::CMD_INSERT, 4'd6,  16'd4,    1'b1, 1'b0, 4'd0},  // equal expiry time
      {dtq_pkg::CMD_INSERT, 4'd5,  16'd1,    1'b1, 1'b0, 4'd0},  // slot already queued
      {dtq_pkg::CMD_INSERT, 4'd9,  16'd6,    1'b1, 1'b0, 4'd0},  // lands mid-list
      {dtq_pkg::CMD_INSERT, 4'd1,  16'd0,    1'b1, 1'b0, 4'd0},
      {dtq_pkg::CMD_TICK,   4'd15, 16'hFFFF, 1'b1, 1'b1, 4'd1},  // tick ignores fields
      {dtq_pkg::CMD_TICK,   4'd0,  16'd0,    1'b0, 1'b0, 4'd0},
      {dtq_pkg::CMD_TICK,   4'd0,  16'd0,    1'b0, 1'b0, 4'd0},
      {dtq_pkg::CMD_TICK,   4'd0,  16'd0,    1'b0, 1'b0, 4'd0},
      {dtq_pkg::CMD_TICK,   4'd0,  16'd0,    1'b0, 1'b0, 4'd0},
      {dtq_pkg::CMD_INSERT, 4'd0,  16'd0,    1'b1, 1'b0, 4'd0},
      {dtq_pkg::CMD_INSERT, 4'd15, 16'd0,    1'b1, 1'b0, 4'd0},
      {dtq_pkg::CMD_TICK,   4'd0,  16'd0,    1'b0, 1'b0, 4'd0},
      {dtq_pkg::CMD_TICK,   4'd0,  16'd0,    1'b0, 1'b0, 4'd0}
   };

   logic clock;
   logic reset;

   dtq_req_if req_bus ();
   dtq_rsp_if rsp_bus ();

   delta_timer_queue u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // model of the delta list
   logic [4:0]                  q_head;
   logic [4:0]                  q_next   [NSLOT];
   logic [dtq_pkg::DELAY_W-1:0] q_delta  [NSLOT];
   logic                        q_queued [NSLOT];

   wake_type    wake_expected [$];
   int unsigned wake_errors = 0;
   int unsigned stuck_cycles;
   int unsigned src_idle_pct;
   int unsigned snk_stall_pct;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one request to the model; returns 0 where the block ignores it.
   function automatic bit predict_wakes(input logic c, input logic [dtq_pkg::SLOT_W-1:0] s,
                                        input logic [dtq_pkg::DELAY_W-1:0] d,
                                        input bit record);
      logic [4:0]                  prev;
      logic [4:0]                  cur;
      logic [4:0]                  h;
      logic [dtq_pkg::DELAY_W-1:0] rem;
      int unsigned                 n;
      prev = NIL_LINK;
      cur  = q_head;
      rem  = d;
      n    = 0;
      if (c == dtq_pkg::CMD_INSERT) begin
         if (q_queued[s]) return 1'b0;
         while (cur != NIL_LINK && q_delta[cur] < rem) begin
            rem  -= q_delta[cur];
            prev  = cur;
            cur   = q_next[cur];
         end
         q_delta[s]  = rem;
         q_next[s]   = cur;
         q_queued[s] = 1'b1;
         if (cur != NIL_LINK) q_delta[cur] -= rem;
         if (prev == NIL_LINK) q_head = {1'b0, s};
         else q_next[prev] = {1'b0, s};
         return 1'b1;
      end
      if (q_head == NIL_LINK) return 1'b0;
      while (n < dtq_pkg::MAX_WAKE && q_head != NIL_LINK && q_delta[q_head] == '0) begin
         h           = q_head;
         q_head      = q_next[h];
         q_queued[h] = 1'b0;
         n++;
         if (record)
            wake_expected.push_back(wake_type'{slot: h[dtq_pkg::SLOT_W-1:0],
               last: !(n < dtq_pkg::MAX_WAKE && q_head != NIL_LINK &&
                       q_delta[q_head] == '0)});
      end
      if (q_head != NIL_LINK && q_delta[q_head] != '0) q_delta[q_head] -= 1'b1;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      wake_errors++;
      if (wake_errors <= MAX_SHOWN) $display("%0t: %s", $realtime, msg);
   endtask

   // Hold valid across back-to-back requests; drop it only for a gap.
   task automatic send_request(input logic c, input logic [dtq_pkg::SLOT_W-1:0] s,
                               input logic [dtq_pkg::DELAY_W-1:0] d, input bit record,
                               output bit took_effect);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= c;
      req_bus.slot  <= s;
      req_bus.delay <= d;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      took_effect = predict_wakes(c, s, d, record);
   endtask

   // result channel: random back-pressure and in-order check
   always @(posedge clock) begin
      wake_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (wake_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected wake: slot %0d last %0b",
                                         rsp_bus.woken_slot, rsp_bus.last));
            end else begin
               want = wake_expected.pop_front();
               if (rsp_bus.woken_slot !== want.slot)
                  report_mismatch($sformatf("woken_slot: expected %0d, got %0d",
                                            want.slot, rsp_bus.woken_slot));
               if (rsp_bus.last !== want.last)
                  report_mismatch($sformatf("last (slot %0d): expected %0b, got %0b",
                                            want.slot, want.last, rsp_bus.last));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int unsigned                 effective;
      int unsigned                 pick;
      int unsigned                 burst_len;
      int unsigned                 k;
      int                          free_slots [$];
      logic [dtq_pkg::DELAY_W-1:0] dly;
      dir_row_type                 row;
      bit                          ok;

      effective     = 0;
      src_idle_pct  = 13;
      snk_stall_pct = 57;
      q_head        = NIL_LINK;
      for (int i = 0; i < NSLOT; i++) q_queued[i] = 1'b0;

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= dtq_pkg::CMD_INSERT;
      req_bus.slot  <= '0;
      req_bus.delay <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // every slot due on the same tick: the widest wake-up a tick can give
      for (int i = 0; i < NSLOT; i++)
         send_request(dtq_pkg::CMD_INSERT, dtq_pkg::SLOT_W'(i), '0, 1'b1, ok);
      send_request(dtq_pkg::CMD_TICK, '0, '0, 1'b1, ok);

      for (int r = 0; r < DIR_ROWS; r++) begin
         row = DIR_TABLE[r];
         send_request(row.cmd, row.slot, row.delay, !row.fixed, ok);
         if (row.fixed && row.fixed_wake)
            wake_expected.push_back(wake_type'{slot: row.fixed_slot, last: 1'b1});
      end

      while (effective < RAND_ITEMS) begin
         if (effective >= 60) begin
            src_idle_pct  = 0;
            snk_stall_pct = 0;
         end else if (effective >= 30) begin
            src_idle_pct  = 57;
            snk_stall_pct = 13;
         end
         free_slots.delete();
         for (int j = 0; j < NSLOT; j++)
            if (!q_queued[j]) free_slots.push_back(j);
         pick = $urandom_range(99);
         if (pick < 45 || free_slots.size() == 0) begin
            send_request(dtq_pkg::CMD_TICK, dtq_pkg::SLOT_W'($urandom()),
                         dtq_pkg::DELAY_W'($urandom()), 1'b1, ok);
            if (ok) effective++;
         end else if (pick < 52) begin
            // any slot, queued or not
            send_request(dtq_pkg::CMD_INSERT, dtq_pkg::SLOT_W'($urandom()),
                         dtq_pkg::DELAY_W'($urandom_range(15)), 1'b1, ok);
            if (ok) effective++;
         end else if (pick < 60) begin
            // several slots sharing one expiry time
            burst_len = $urandom_range(2, 5);
            dly       = dtq_pkg::DELAY_W'($urandom_range(3));
            for (int b = 0; b < burst_len && free_slots.size() != 0; b++) begin
               k = $urandom_range(free_slots.size() - 1);
               send_request(dtq_pkg::CMD_INSERT, dtq_pkg::SLOT_W'(free_slots[k]), dly,
                            1'b1, ok);
               free_slots.delete(k);
               if (ok) effective++;
            end
         end else begin
            k    = $urandom_range(free_slots.size() - 1);
            pick = $urandom_range(99);
            if (pick < 70) dly = dtq_pkg::DELAY_W'($urandom_range(7));
            else if (pick < 96) dly = dtq_pkg::DELAY_W'($urandom_range(60));
            else dly = dtq_pkg::DELAY_W'($urandom());
            send_request(dtq_pkg::CMD_INSERT, dtq_pkg::SLOT_W'(free_slots[k]), dly,
                         1'b1, ok);
            if (ok) effective++;
         end
      end
      req_bus.valid <= 1'b0;

      while (wake_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (wake_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
